### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the ring completion tracker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/dmarct_pkg.sv
// ---------------------------------------------------------------------------
// dmarct_pkg
// Types and constants shared by the DMA ring completion tracker.
// ---------------------------------------------------------------------------
package dmarct_pkg;

   localparam int RING_DEPTH_DEFAULT = 256;
   localparam int INDEX_W            = 8;
   localparam int EPOCH_W            = 32;
   localparam int REQ_DATA_W         = 48;
   localparam int REQ_USER_W         = 2;
   localparam int RSP_DATA_W         = 48;
   localparam int RSP_PAD_W          = RSP_DATA_W - (2 + INDEX_W + EPOCH_W);

   typedef enum logic {
      OP_ISSUE = 1'b0,
      OP_CHECK = 1'b1
   } op_type;

   typedef enum logic {
      CH_TX = 1'b0,
      CH_RX = 1'b1
   } chan_type;

   // request layout, lowest bits last: matches {tdata, tuser}
   typedef struct packed {
      logic [EPOCH_W-1:0] target_epoch;
      logic [INDEX_W-1:0] target_index;
      logic [INDEX_W-1:0] head_index;
      chan_type           channel;
      op_type             operation;
   } req_item_type;

   // response layout, matches rsp_tdata
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic                 done_res;
      logic [EPOCH_W-1:0]   epoch_now;
      logic [INDEX_W-1:0]   tail_now;
      logic                 accepted;
   } rsp_item_type;

   // ring state write control
   typedef struct packed {
      logic     wr_en;
      chan_type chan;
   } ring_wr_type;

endpackage

### rtl/dma_ring_completion_tracker_core.sv
// ---------------------------------------------------------------------------
// dma_ring_completion_tracker_core
// Tail/epoch tracker for the transmit and receive DMA command rings.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* carries one request: an issue (advance the ring tail) or a check
//    (has the command at target_index/target_epoch completed?). The caller
//    supplies the ring's current hardware head pointer with every request.
//  - rsp_* returns exactly one response per request, in order: accepted
//    (issue taken, 0 on ring full), tail and epoch after the request, and
//    done_res for checks.
//  - From req acceptance to rsp_tvalid a request passes the input register,
//    then the result register. Throughput: one request per cycle while
//    rsp_tready does not stall, set by the tail/epoch update loop through the ring registers.
//  - A stalled rsp_tready holds the response; one more request is taken
//    into the input register, then req_tready drops until the result
//    register drains.
//  - Reset (synchronous, active high) clears both tails and epochs and
//    drops all valids. No configuration registers.
// ---------------------------------------------------------------------------
module dma_ring_completion_tracker_core
   import dmarct_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] head_index, [15:8] target_index, [47:16] target_epoch
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] operation, [1] channel
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] accepted, [8:1] tail_now, [40:9] epoch_now, [41] done_res,
   // [47:42] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int TAIL_W = $clog2(RING_DEPTH);

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_ff, in_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic               req_fire;
   logic               advance;
   ring_wr_type        ring_wr;
   logic [TAIL_W-1:0]  cur_tail, new_tail;
   logic [EPOCH_W-1:0] cur_epoch, new_epoch;
   rsp_item_type       step_rsp;

   // input stage moves on whenever the result register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_in       = req_item_type'({req_tdata, req_tuser});
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = step_rsp;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   // ring state, read for the request's channel, written when an accepted issue retires
   dmarct_ring_regs #(
      .TAIL_W (TAIL_W)
   ) u_regs (
      .clock    (clock),
      .reset    (reset),
      .ring_wr  (ring_wr),
      .wr_tail  (new_tail),
      .wr_epoch (new_epoch),
      .rd_chan  (in_ff.channel),
      .rd_tail  (cur_tail),
      .rd_epoch (cur_epoch)
   );

   dmarct_step #(
      .RING_DEPTH (RING_DEPTH)
   ) u_step (
      .fire      (advance),
      .item      (in_ff),
      .cur_tail  (cur_tail),
      .cur_epoch (cur_epoch),
      .ring_wr   (ring_wr),
      .new_tail  (new_tail),
      .new_epoch (new_epoch),
      .result    (step_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

### rtl/dmarct_ring_regs.sv
// ---------------------------------------------------------------------------
// dmarct_ring_regs
// Tail pointer and wrap epoch registers for the transmit and receive rings.
// ---------------------------------------------------------------------------
module dmarct_ring_regs
   import dmarct_pkg::*;
#(
   parameter int TAIL_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  ring_wr_type        ring_wr,
   input  logic [TAIL_W-1:0]  wr_tail,
   input  logic [EPOCH_W-1:0] wr_epoch,
   input  chan_type           rd_chan,
   output logic [TAIL_W-1:0]  rd_tail,
   output logic [EPOCH_W-1:0] rd_epoch
);

   logic [TAIL_W-1:0]  tail_ff  [2];
   logic [EPOCH_W-1:0] epoch_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            tail_ff[k]  <= '0;
            epoch_ff[k] <= '0;
         end
      end else if (ring_wr.wr_en) begin
         tail_ff[ring_wr.chan]  <= wr_tail;
         epoch_ff[ring_wr.chan] <= wr_epoch;
      end
   end

   assign rd_tail  = tail_ff[rd_chan];
   assign rd_epoch = epoch_ff[rd_chan];

endmodule

### rtl/dmarct_step.sv
// ---------------------------------------------------------------------------
// dmarct_step
// Per-request logic: ring-full test, tail advance, completion check.
// ---------------------------------------------------------------------------
module dmarct_step
   import dmarct_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                                fire,
   input  req_item_type                        item,
   input  logic [$clog2(RING_DEPTH)-1:0]       cur_tail,
   input  logic [EPOCH_W-1:0]                  cur_epoch,
   output ring_wr_type                         ring_wr,
   output logic [$clog2(RING_DEPTH)-1:0]       new_tail,
   output logic [EPOCH_W-1:0]                  new_epoch,
   output rsp_item_type                        result
);

   localparam int TAIL_W = $clog2(RING_DEPTH);
   localparam int CMP_W  = (TAIL_W > INDEX_W) ? TAIL_W : INDEX_W;

   logic [TAIL_W-1:0]  tail_inc;
   logic               at_last;
   logic               full;
   logic               take;
   logic [CMP_W-1:0]   h, t, i, inc_x, after_x;
   logic [EPOCH_W-1:0] e_inc;
   logic               done;

   assign at_last  = (cur_tail == TAIL_W'(RING_DEPTH - 1));
   assign tail_inc = at_last ? '0 : cur_tail + 1'b1;

   assign h     = CMP_W'(item.head_index);
   assign i     = CMP_W'(item.target_index);
   assign t     = CMP_W'(cur_tail);
   assign inc_x = CMP_W'(tail_inc);

   assign full = (inc_x == h);
   assign take = (item.operation == OP_ISSUE) && !full;

   assign new_tail  = take ? tail_inc : cur_tail;
   assign new_epoch = (take && at_last) ? cur_epoch + 1'b1 : cur_epoch;

   assign ring_wr.wr_en = fire && take;
   assign ring_wr.chan  = item.channel;

   // completion rules
   assign e_inc = item.target_epoch + 1'b1;
   always_comb begin
      done = 1'b0;
      if (h == t) begin
         done = 1'b1;
      end else if (h < i) begin
         if (t < i) begin
            done = (t > h) || (cur_epoch != e_inc);
         end else begin
            done = (cur_epoch != item.target_epoch);
         end
      end else if (h == i) begin
         done = 1'b1;
      end else begin
         done = (t < i) || (t > h) || (cur_epoch != item.target_epoch);
      end
   end

   assign after_x = CMP_W'(new_tail);

   always_comb begin
      result           = '0;
      result.accepted  = take;
      result.tail_now  = after_x[INDEX_W-1:0];
      result.epoch_now = new_epoch;
      result.done_res  = (item.operation == OP_CHECK) && done;
   end

endmodule

### rtl/dmarct_checker.sv
// ---------------------------------------------------------------------------
// dmarct_checker
// Port-level checks for the ring completion tracker, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dmarct_checker
   import dmarct_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [REQ_USER_W-1:0] req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_item_type rsp;
   logic         req_unused;

   assign rsp        = rsp_tdata;
   assign req_unused = req_tvalid && (|req_tdata) && (|req_tuser);

   // stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // an empty result register never back-pressures the requester
   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready || req_unused)

   // a response is either an issue outcome or a check outcome, never both
   `ASSERT_IMPLY(a_acc_done_excl, clock, reset, rsp_tvalid, !(rsp.accepted && rsp.done_res))

   // reset drains the response channel
   `ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind dma_ring_completion_tracker_core dmarct_checker u_dmarct_checker (.*);
